// ----- hdl/gpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Gait phase estimator package
// Shared widths and the status bundle of the serial divider.
// ----------------------------------------------------------------------------
package gpe_pkg;

  // dividend holds elapsed_ms * 10000 (below 2^30) or a stride period sum
  localparam int DVD_W = 30;
  // divisor holds a mean stride period or the stride count
  localparam int DSR_W = 16;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/gpe_serdiv.sv -----
// ----------------------------------------------------------------------------
// Gait phase estimator serial divider
// Restoring divider, one quotient bit per cycle; the quotient holds until
// the next start.
// ----------------------------------------------------------------------------
module gpe_serdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gpe_pkg::DVD_W-1:0]    dividend_i,
  input  logic [gpe_pkg::DSR_W-1:0]    divisor_i,
  output gpe_pkg::div_stat_t           stat_o,
  output logic [gpe_pkg::DVD_W-1:0]    quotient_o
);

  localparam int CNT_W = $clog2(gpe_pkg::DVD_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [gpe_pkg::DSR_W-1:0]   rem_q, rem_d;
  logic [gpe_pkg::DSR_W-1:0]   dsr_q, dsr_d;
  logic [gpe_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [gpe_pkg::DSR_W:0]     trial;
  logic [gpe_pkg::DSR_W:0]     diff;
  logic                        fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[gpe_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[gpe_pkg::DSR_W-1:0] : trial[gpe_pkg::DSR_W-1:0];
      quo_d = {quo_q[gpe_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(gpe_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ----- hdl/gait_phase_estimator.sv -----
// ----------------------------------------------------------------------------
// Gait phase estimator
// Heel-strike calibration of the mean stride period and tracking of the gait
// phase with a once-per-cycle actuate pulse.
// ----------------------------------------------------------------------------
// Each accepted item passes through the finish state into the output register;
//   items that divide (tracking ticks and strikes, the last stride) first wait
//   in the divide state for the serial divider, which retires one of 30
//   quotient bits a cycle. A new item is taken only once the sequencer is idle.
// Input is taken while a result still waits in the output register.
// Reset: asynchronous, active low; the block idles with no mean period known.
module gait_phase_estimator #(
  parameter int CAL_STRIDES = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] sensor_sample
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [2:0] stride_count, [16:3] phase_centi,
                                        // [32:17] mean_period_ms, [33] actuate
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int CNT_W = $clog2(CAL_STRIDES + 1);
  localparam int SUM_W = 16 + CNT_W;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_CAL   = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_IDLE    = 3'd0;
  localparam logic [2:0] STAT_WAIT    = 3'd1;
  localparam logic [2:0] STAT_STRIDE  = 3'd2;
  localparam logic [2:0] STAT_CALIB   = 3'd3;
  localparam logic [2:0] STAT_PHASE   = 3'd4;
  localparam logic [2:0] STAT_STOPPED = 3'd5;
  localparam logic [2:0] STAT_NOCAL   = 3'd6;

  // gait run states
  localparam logic [2:0] RUN_IDLE       = 3'd0;
  localparam logic [2:0] RUN_CAL_WAIT   = 3'd1;
  localparam logic [2:0] RUN_CAL_COUNT  = 3'd2;
  localparam logic [2:0] RUN_TRACK_WAIT = 3'd3;
  localparam logic [2:0] RUN_TRACKING   = 3'd4;

  // item sequencer states
  localparam logic [1:0] FSM_IDLE = 2'd0;
  localparam logic [1:0] FSM_DIV  = 2'd1;
  localparam logic [1:0] FSM_FIN  = 2'd2;

  // what to do with the quotient
  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_MEAN  = 2'd1;
  localparam logic [1:0] POST_PHASE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HEEL_THR = 2'd0;
  localparam logic [1:0] CFG_MIN_STR  = 2'd1;
  localparam logic [1:0] CFG_ACT_PCT  = 2'd2;
  localparam logic [1:0] CFG_WINDOW   = 2'd3;

  localparam logic [gpe_pkg::DVD_W-1:0] PHASE_SCALE = gpe_pkg::DVD_W'(10000);
  localparam logic [gpe_pkg::DVD_W-1:0] PHASE_FULL  = gpe_pkg::DVD_W'(10000);

  // configuration registers
  logic [11:0] heel_thr_q;
  logic [15:0] min_stride_q;
  logic [6:0]  act_pct_q;
  logic [9:0]  window_q;

  // gait state
  logic [2:0]       run_q, run_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [CNT_W-1:0] strides_q, strides_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [15:0]      mean_q, mean_d;
  logic             fired_q, fired_d;

  // sequencer and the result being built
  logic [1:0]  fsm_q, fsm_d;
  logic [1:0]  post_q, post_d;
  logic [2:0]  pst_status_q, pst_status_d;
  logic [13:0] pst_phase_q, pst_phase_d;
  logic        pst_act_q, pst_act_d;

  // output register
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic [2:0]  out_user_q;
  logic        out_load;

  // divider hookup
  logic                        div_start;
  logic [gpe_pkg::DVD_W-1:0]   div_dvd;
  logic [gpe_pkg::DSR_W-1:0]   div_dsr;
  gpe_pkg::div_stat_t          div_stat;
  logic [gpe_pkg::DVD_W-1:0]   div_quo;

  // per-item helpers
  logic             in_xfer;
  logic [1:0]       mode;
  logic [11:0]      sample;
  logic [15:0]      elapsed_inc;
  logic [CNT_W-1:0] strides_inc;
  logic [SUM_W-1:0] sum_new;
  logic [15:0]      phase_time;
  logic [13:0]      target;
  logic             wrap;
  logic [13:0]      phase_w;
  logic [13:0]      phase_gap;
  logic             fired_now;
  logic [CNT_W+2:0] strides_ext;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign mode    = s_axis_tuser_i;
  assign sample  = s_axis_tdata_i[11:0];

  // saturate the millisecond timer
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign strides_inc = strides_q + 1'b1;
  assign sum_new     = sum_q + SUM_W'(elapsed_inc);

  // phase post-processing on the finished quotient
  assign target    = 14'(act_pct_q) * 14'd100;
  assign wrap      = div_quo >= PHASE_FULL;
  assign phase_w   = wrap ? 14'd0 : div_quo[13:0];
  assign phase_gap = (phase_w >= target) ? phase_w - target : target - phase_w;
  assign fired_now = fired_q && !wrap;

  always_comb begin
    run_d        = run_q;
    elapsed_d    = elapsed_q;
    strides_d    = strides_q;
    sum_d        = sum_q;
    mean_d       = mean_q;
    fired_d      = fired_q;
    fsm_d        = fsm_q;
    post_d       = post_q;
    pst_status_d = pst_status_q;
    pst_phase_d  = pst_phase_q;
    pst_act_d    = pst_act_q;
    div_start    = 1'b0;
    div_dvd      = '0;
    div_dsr      = '0;
    phase_time   = '0;
    out_load     = 1'b0;

    case (fsm_q)
      FSM_IDLE: begin
        if (in_xfer) begin
          fsm_d       = FSM_FIN;
          post_d      = POST_NONE;
          pst_phase_d = '0;
          pst_act_d   = 1'b0;
          case (mode)
            MODE_CAL: begin
              run_d        = RUN_CAL_WAIT;
              elapsed_d    = '0;
              strides_d    = '0;
              sum_d        = '0;
              pst_status_d = STAT_WAIT;
            end
            MODE_TRACK: begin
              elapsed_d = '0;
              fired_d   = 1'b0;
              if (mean_q == '0) begin
                run_d        = RUN_IDLE;
                pst_status_d = STAT_NOCAL;
              end else begin
                run_d        = RUN_TRACK_WAIT;
                pst_status_d = STAT_WAIT;
              end
            end
            MODE_STOP: begin
              run_d        = RUN_IDLE;
              elapsed_d    = '0;
              fired_d      = 1'b0;
              pst_status_d = STAT_STOPPED;
            end
            default: begin
              // tick with a sensor sample
              case (run_q)
                RUN_CAL_WAIT: begin
                  pst_status_d = STAT_WAIT;
                  if (sample >= heel_thr_q) begin
                    run_d     = RUN_CAL_COUNT;
                    elapsed_d = '0;
                  end
                end
                RUN_CAL_COUNT: begin
                  elapsed_d    = elapsed_inc;
                  pst_status_d = STAT_WAIT;
                  if (sample > heel_thr_q && elapsed_inc > min_stride_q) begin
                    strides_d    = strides_inc;
                    sum_d        = sum_new;
                    elapsed_d    = '0;
                    pst_status_d = STAT_STRIDE;
                    if (strides_inc >= CNT_W'(CAL_STRIDES)) begin
                      // rounded mean of the recorded periods
                      run_d        = RUN_IDLE;
                      pst_status_d = STAT_CALIB;
                      post_d       = POST_MEAN;
                      fsm_d        = FSM_DIV;
                      div_start    = 1'b1;
                      div_dvd      = gpe_pkg::DVD_W'(sum_new) +
                                     gpe_pkg::DVD_W'(CAL_STRIDES / 2);
                      div_dsr      = gpe_pkg::DSR_W'(CAL_STRIDES);
                    end
                  end
                end
                RUN_TRACK_WAIT: begin
                  pst_status_d = STAT_WAIT;
                  if (sample >= heel_thr_q) begin
                    // the strike itself is phase zero
                    run_d        = RUN_TRACKING;
                    elapsed_d    = '0;
                    fired_d      = 1'b0;
                    pst_status_d = STAT_PHASE;
                    post_d       = POST_PHASE;
                    fsm_d        = FSM_DIV;
                    div_start    = 1'b1;
                    phase_time   = '0;
                    div_dvd      = gpe_pkg::DVD_W'(phase_time) * PHASE_SCALE;
                    div_dsr      = mean_q;
                  end
                end
                RUN_TRACKING: begin
                  elapsed_d    = elapsed_inc;
                  pst_status_d = STAT_PHASE;
                  post_d       = POST_PHASE;
                  fsm_d        = FSM_DIV;
                  div_start    = 1'b1;
                  phase_time   = elapsed_inc;
                  div_dvd      = gpe_pkg::DVD_W'(phase_time) * PHASE_SCALE;
                  div_dsr      = mean_q;
                end
                default: begin
                  run_d        = RUN_IDLE;
                  pst_status_d = STAT_IDLE;
                end
              endcase
            end
          endcase
        end
      end
      FSM_DIV: begin
        if (div_stat.done) begin
          fsm_d = FSM_FIN;
          case (post_q)
            POST_MEAN: begin
              mean_d = div_quo[15:0];
            end
            POST_PHASE: begin
              // wrap at a full cycle, then fire once inside the window
              if (wrap) begin
                elapsed_d = '0;
              end
              pst_phase_d = phase_w;
              if (phase_gap <= 14'(window_q) && !fired_now) begin
                fired_d   = 1'b1;
                pst_act_d = 1'b1;
              end else begin
                fired_d   = fired_now;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          fsm_d    = FSM_IDLE;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  gpe_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // configuration writes are taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heel_thr_q   <= 12'd819;
      min_stride_q <= 16'd800;
      act_pct_q    <= 7'd30;
      window_q     <= 10'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HEEL_THR: heel_thr_q   <= cfg_data_i[11:0];
        CFG_MIN_STR:  min_stride_q <= cfg_data_i;
        CFG_ACT_PCT:  act_pct_q    <= cfg_data_i[6:0];
        CFG_WINDOW:   window_q     <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= RUN_IDLE;
      elapsed_q   <= '0;
      strides_q   <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      fired_q     <= 1'b0;
      fsm_q       <= FSM_IDLE;
      post_q      <= POST_NONE;
      out_valid_q <= 1'b0;
    end else begin
      run_q     <= run_d;
      elapsed_q <= elapsed_d;
      strides_q <= strides_d;
      sum_q     <= sum_d;
      mean_q    <= mean_d;
      fired_q   <= fired_d;
      fsm_q     <= fsm_d;
      post_q    <= post_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stride count leaves as its low three bits
  assign strides_ext = {3'b000, strides_q};

  always_ff @(posedge clk_i) begin
    pst_status_q <= pst_status_d;
    pst_phase_q  <= pst_phase_d;
    pst_act_q    <= pst_act_d;
    if (out_load) begin
      out_user_q <= pst_status_q;
      out_data_q <= {6'd0, pst_act_q, mean_q, pst_phase_q, strides_ext[2:0]};
    end
  end

  assign s_axis_tready_o = (fsm_q == FSM_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  // a pulse only ever accompanies a phase result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[33]) |-> (m_axis_tuser_o == STAT_PHASE))
    else $error("actuate raised outside a phase result");

  // a reported phase has already wrapped below a full cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[16:3] < 14'd10000))
    else $error("phase at or beyond a full cycle");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (fsm_q == FSM_DIV))
    else $error("divider finished outside the divide state");

  // no new item while the divider still runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_stat.busy)
    else $error("input taken while the divider is busy");

  // a division starts only on an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> in_xfer)
    else $error("divider started without an input transfer");
`endif

endmodule
